>>> rtl/utw_pkg.sv
// ----------------------------------------------------------------------------
// utw_pkg
// shared types and constants for the utf-8 word tokenizer
// ----------------------------------------------------------------------------
package utw_pkg;

	// text and word size limits
	localparam int MAX_TEXT_BYTES = 65536;
	localparam int MAX_WORD_BYTES = 256;
	// longest kept word plus one, bounded by the 8-bit length field
	localparam int LEN_LIMIT      = (MAX_WORD_BYTES < 256) ? MAX_WORD_BYTES : 256;

	// byte position saturates here
	localparam logic [15:0] POS_LIMIT     = (MAX_TEXT_BYTES - 1 < 65535) ?
		16'(MAX_TEXT_BYTES - 1) : 16'hFFFF;
	// word limit after reset
	localparam logic [15:0] MAX_WORDS_RST = 16'hFFFF;

	// one text byte as it arrives
	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_last;
	} item_t;

	// one word descriptor
	typedef struct packed {
		logic [15:0] word_offset;
		logic [7:0]  word_bytes;
		logic        has_cyrillic;
		logic        has_latin;
		logic [15:0] word_number;
	} word_t;

	// one completed character, classified, passed from front to back
	typedef struct packed {
		logic        is_word;
		logic        is_cyr;
		logic        is_lat;
		logic [15:0] char_start;
		logic [15:0] char_end;
		logic        last;
	} char_ev_t;

endpackage

>>> rtl/utf8_word_tokenizer.sv
// ----------------------------------------------------------------------------
// utf8_word_tokenizer
// streaming utf-8 decoder that splits text into word descriptors
//
//   channel   handshake            payload
//   -------   ------------------   -------------------------------
//   text      push / full          text_item (byte, last flag)
//   words     empty / pop          word (offset, length, flags, number)
//   config    cfg_valid/cfg_ready  cfg_data (max_words)
//
// one byte is taken per cycle while not full; the decoder front and the word
// tracker back are joined by a two-entry queue; the event of the byte that
// closes a word is registered there, its descriptor then in the result queue;
// a stalled result side fills the queues, then full rises
// reset clears all stream state and sets max_words to 65535; no sweep
// ----------------------------------------------------------------------------
module utf8_word_tokenizer
	import utw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  item_t       text_item,
	output logic        empty,
	input  logic        pop,
	output word_t       word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic        ev_valid;
	logic        ev_pop;
	char_ev_t    ev;
	logic [15:0] max_words_q;

	assign cfg_ready = 1'b1;

	// word limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_words_q <= MAX_WORDS_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_words_q <= cfg_data;
		end
	end

	utw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.text_item (text_item),
		.ev_valid  (ev_valid),
		.ev_pop    (ev_pop),
		.ev        (ev)
	);

	utw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (ev_valid),
		.ev_pop    (ev_pop),
		.ev        (ev),
		.max_words (max_words_q),
		.empty     (empty),
		.pop       (pop),
		.word      (word)
	);

endmodule

>>> rtl/utw_front.sv
// ----------------------------------------------------------------------------
// utw_front
// utf-8 decoder: assembles code points, classifies them and queues one
// character event per completed character or per character cut short by the final byte (two-entry queue)
// ----------------------------------------------------------------------------
module utw_front
	import utw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  item_t    text_item,
	output logic     ev_valid,
	input  logic     ev_pop,
	output char_ev_t ev
);

	localparam logic [20:0] CYR_LO    = 21'h000400;
	localparam logic [20:0] CYR_HI    = 21'h00052F;
	localparam logic [20:0] CODE_HYP  = 21'h00002D;
	localparam logic [20:0] CODE_APOS = 21'h000027;
	localparam logic [20:0] UC_A      = 21'h000041;
	localparam logic [20:0] UC_Z      = 21'h00005A;
	localparam logic [20:0] LC_A      = 21'h000061;
	localparam logic [20:0] LC_Z      = 21'h00007A;
	localparam logic [5:0]  CONT_MASK = 6'h3F;

	// decoder state
	logic [1:0]  pend_q;
	logic [20:0] acc_q;
	logic [15:0] cstart_q;
	logic [15:0] pos_q;

	// event queue
	char_ev_t    mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;

	logic        accept;
	logic [1:0]  pend_n;
	logic [20:0] acc_n;
	logic [15:0] start_n;
	logic [15:0] pos1;
	logic [16:0] trunc_sum;
	logic [20:0] code;
	logic [15:0] end_pos;
	logic        done;
	logic        ev_push;
	logic        cyr;
	logic        lat;
	char_ev_t    ev_new;

	assign full     = (cnt_q == 2'd2);
	assign accept   = push && !full;
	assign ev_valid = (cnt_q != 2'd0);
	assign ev       = mem_q[rd_q];

	// lead and continuation byte decode
	always_comb begin
		pend_n  = 2'd0;
		acc_n   = {13'd0, text_item.text_byte};
		start_n = cstart_q;
		if (pend_q == 2'd0) begin
			start_n = pos_q;
			if (text_item.text_byte[7] == 1'b0) begin
				acc_n = {13'd0, text_item.text_byte};
			end else if (text_item.text_byte[7:5] == 3'b110) begin
				acc_n  = {16'd0, text_item.text_byte[4:0]};
				pend_n = 2'd1;
			end else if (text_item.text_byte[7:4] == 4'b1110) begin
				acc_n  = {17'd0, text_item.text_byte[3:0]};
				pend_n = 2'd2;
			end else if (text_item.text_byte[7:3] == 5'b11110) begin
				acc_n  = {18'd0, text_item.text_byte[2:0]};
				pend_n = 2'd3;
			end
		end else begin
			acc_n  = {acc_q[14:0], text_item.text_byte[5:0] & CONT_MASK};
			pend_n = pend_q - 2'd1;
		end
	end

	assign done      = (pend_n == 2'd0);
	assign pos1      = (pos_q == POS_LIMIT) ? pos_q : pos_q + 16'd1;
	assign trunc_sum = {1'b0, pos1} + {15'd0, pend_n};

	// completed or truncated character: code and end position
	always_comb begin
		case (pend_n)
			2'd1:    code = {acc_n[14:0], 6'd0};
			2'd2:    code = {acc_n[8:0], 12'd0};
			2'd3:    code = {acc_n[2:0], 18'd0};
			default: code = acc_n;
		endcase
		if (done) begin
			end_pos = pos1;
		end else begin
			end_pos = (trunc_sum > {1'b0, POS_LIMIT}) ? POS_LIMIT : trunc_sum[15:0];
		end
	end

	// character classes
	assign cyr = (code >= CYR_LO) && (code <= CYR_HI);
	assign lat = ((code >= UC_A) && (code <= UC_Z)) || ((code >= LC_A) && (code <= LC_Z));

	always_comb begin
		ev_new.is_word    = cyr || lat || (code == CODE_HYP) || (code == CODE_APOS);
		ev_new.is_cyr     = cyr;
		ev_new.is_lat     = lat;
		ev_new.char_start = start_n;
		ev_new.char_end   = end_pos;
		ev_new.last       = text_item.text_last;
	end

	assign ev_push = accept && (done || text_item.text_last);

	// decoder registers, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 2'd0;
			acc_q    <= '0;
			cstart_q <= '0;
			pos_q    <= '0;
		end else if (accept) begin
			if (text_item.text_last) begin
				pend_q   <= 2'd0;
				acc_q    <= '0;
				cstart_q <= '0;
				pos_q    <= '0;
			end else begin
				pend_q   <= pend_n;
				acc_q    <= acc_n;
				cstart_q <= start_n;
				pos_q    <= pos1;
			end
		end
	end

	// event queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (ev_push) begin
				wr_q <= ~wr_q;
			end
			if (ev_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, ev_push} - {1'b0, ev_pop};
		end
	end

	// event queue storage
	always_ff @(posedge clk) begin
		if (ev_push) begin
			mem_q[wr_q] <= ev_new;
		end
	end

endmodule

>>> rtl/utw_back.sv
// ----------------------------------------------------------------------------
// utw_back
// word tracker: consumes character events, closes words and queues
// descriptors in a two-entry result queue
// ----------------------------------------------------------------------------
module utw_back
	import utw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ev_valid,
	output logic        ev_pop,
	input  char_ev_t    ev,
	input  logic [15:0] max_words,
	output logic        empty,
	input  logic        pop,
	output word_t       word
);

	// word state
	logic        in_word_q;
	logic [15:0] wstart_q;
	logic        cyr_q;
	logic        lat_q;
	logic [15:0] words_q;

	// result queue
	word_t       mem_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;

	logic        out_full;
	logic        out_pop;
	logic        in_word_n;
	logic [15:0] wstart_n;
	logic        cyr_n;
	logic        lat_n;
	logic        do_close;
	logic [15:0] close_pos;
	logic [16:0] diff;
	logic        len_ok;
	logic        emit;
	logic [15:0] words_inc;
	word_t       word_new;

	assign out_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign out_pop  = pop && !empty;
	assign word     = mem_q[rd_q];
	assign ev_pop   = ev_valid && !out_full;

	// open or extend the word on a word character
	always_comb begin
		in_word_n = in_word_q;
		wstart_n  = wstart_q;
		cyr_n     = cyr_q;
		lat_n     = lat_q;
		if (ev.is_word) begin
			if (!in_word_q) begin
				in_word_n = 1'b1;
				wstart_n  = ev.char_start;
				cyr_n     = 1'b0;
				lat_n     = 1'b0;
			end
			cyr_n = cyr_n || ev.is_cyr;
			lat_n = lat_n || ev.is_lat;
		end
	end

	// close on a non-word character or at the final byte
	assign do_close  = (!ev.is_word && in_word_q) || (ev.last && in_word_n);
	assign close_pos = ev.is_word ? ev.char_end : ev.char_start;
	assign diff      = {1'b0, close_pos} - {1'b0, wstart_n};
	assign len_ok    = !diff[16] && (diff[15:0] != 16'd0) && (diff[15:0] < 16'(LEN_LIMIT));
	assign emit      = ev_pop && do_close && len_ok && (words_q < max_words);
	assign words_inc = words_q + 16'd1;

	always_comb begin
		word_new.word_offset  = wstart_n;
		word_new.word_bytes   = diff[7:0];
		word_new.has_cyrillic = cyr_n;
		word_new.has_latin    = lat_n;
		word_new.word_number  = words_inc;
	end

	// word state registers, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q <= 1'b0;
			wstart_q  <= '0;
			cyr_q     <= 1'b0;
			lat_q     <= 1'b0;
			words_q   <= '0;
		end else if (ev_pop) begin
			if (ev.last) begin
				in_word_q <= 1'b0;
				wstart_q  <= '0;
				cyr_q     <= 1'b0;
				lat_q     <= 1'b0;
				words_q   <= '0;
			end else begin
				in_word_q <= in_word_n && !do_close;
				wstart_q  <= wstart_n;
				cyr_q     <= cyr_n;
				lat_q     <= lat_n;
				if (emit) begin
					words_q <= words_inc;
				end
			end
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (emit) begin
				wr_q <= ~wr_q;
			end
			if (out_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, emit} - {1'b0, out_pop};
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (emit) begin
			mem_q[wr_q] <= word_new;
		end
	end

endmodule

>>> rtl/utw_checker.sv
// ----------------------------------------------------------------------------
// utw_checker
// port-level checks on the tokenizer, attached by bind
// ----------------------------------------------------------------------------
module utw_checker
	import utw_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input word_t       word,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [15:0] cfg_data
);

	logic [15:0] limit_q;
	logic [16:0] word_end;

	// shadow of the word limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= MAX_WORDS_RST;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	assign word_end = {1'b0, word.word_offset} + {9'd0, word.word_bytes};

	// a waiting result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(word)))
		else $error("result changed before transfer");

	// reset leaves both queues empty
	a_reset: assert property (@(posedge clk) !arst_n |=> (empty && !full))
		else $error("queues not empty in reset");

	// a descriptor has a length and stays inside the text
	a_shape: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (word.word_bytes != 8'd0 && word.word_number != 16'd0 &&
		word_end <= 17'h0FFFF))
		else $error("malformed word descriptor");

	// word numbers never pass the configured limit
	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (word.word_number <= limit_q))
		else $error("word number above limit");

endmodule

bind utf8_word_tokenizer utw_checker u_utw_checker (.*);
